// File: rtl/core/tss_pkg.sv
// tridiagonal solver package: sizes, state types and Q8.24 helpers
// no dependencies
`timescale 1ns / 1ps

package tss_pkg;

   localparam int MAX_ROWS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 24;

   typedef logic [ROW_W-1:0]         row_idx_type;
   typedef logic signed [DATA_W-1:0] q_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_R,
      ST_MUL_R,
      ST_PIV,
      ST_MUL_G,
      ST_NUM,
      ST_GDIV,
      ST_DIV_G,
      ST_EMIT,
      ST_RD,
      ST_BSUB
   } tss_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_DONE
   } tss_div_state_type;

   // divider handshake toward the sequencer
   typedef struct packed {
      logic  done;
      logic  zero;
      q_type quot;
   } tss_div_rsp_type;

   function automatic logic [DATA_W-1:0] mag32(input q_type v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // rounded Q8.24 product from magnitude and sign, ties away from zero
   function automatic logic signed [41:0] qround(input logic [63:0] p, input logic neg);
      logic [63:0] r;
      logic signed [41:0] s;
      r = (p + 64'(1 << (FRAC_W - 1))) >> FRAC_W;
      s = $signed({2'b00, r[39:0]});
      return neg ? -s : s;
   endfunction

   function automatic q_type sat32(input logic signed [42:0] v);
      q_type r;
      if (v > 43'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -43'sd2147483648) r = 32'sh80000000;
      else                           r = v[DATA_W-1:0];
      return r;
   endfunction

endpackage

// File: rtl/core/tss_if.sv
// request and response channel interfaces of the tridiagonal solver
// depends on tss_pkg
`timescale 1ns / 1ps

interface tss_req_if;
   logic                valid;
   logic                ready;
   tss_pkg::q_type      sub_diag;
   tss_pkg::q_type      main_diag;
   tss_pkg::q_type      super_diag;
   tss_pkg::q_type      rhs_value;
   logic                last_row;
   modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                   input ready);
   modport sink   (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                   output ready);
endinterface

interface tss_rsp_if;
   logic                  valid;
   logic                  ready;
   tss_pkg::row_idx_type  row_index;
   tss_pkg::q_type        solution;
   logic                  singular;
   logic                  last_out;
   modport source (output valid, row_index, solution, singular, last_out, input ready);
   modport sink   (input valid, row_index, solution, singular, last_out, output ready);
endinterface

// File: rtl/core/tss_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// File: rtl/core/tss_div.sv
// radix-2 restoring divider for rounded, saturated Q8.24 quotients
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  tss_pkg::q_type            num,
   input  tss_pkg::q_type            den,
   output tss_pkg::tss_div_rsp_type  rsp
);
   import tss_pkg::*;

   tss_div_state_type state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [32:0]       rem_ff, rem_in;
   logic [31:0]       lo_ff, lo_in;
   logic [31:0]       ud_ff, ud_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;

   logic [31:0] ud_s;
   logic [55:0] dividend;
   logic [32:0] shifted;
   logic        ge;

   // operand setup and one quotient bit per cycle
   always_comb begin
      ud_s     = mag32(den);
      dividend = {mag32(num), 24'b0} + 56'(ud_s >> 1);
      shifted  = {rem_ff[31:0], lo_ff[31]};
      ge       = shifted >= {1'b0, ud_ff};
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      ud_in    = ud_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               ud_in   = ud_s;
               neg_in  = num[31] ^ den[31];
               zero_in = (ud_s == '0);
               cnt_in  = '1;
               rem_in  = {9'b0, dividend[55:32]};
               lo_in   = dividend[31:0];
               if (ud_s == '0) begin
                  lo_in    = '0;
                  state_in = DV_DONE;
               end else if ({8'b0, dividend[55:32]} >= ud_s) begin
                  lo_in    = '1;
                  state_in = DV_DONE;
               end else begin
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            rem_in = ge ? (shifted - {1'b0, ud_ff}) : shifted;
            lo_in  = {lo_ff[30:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   // signed result with saturation
   always_comb begin
      rsp.done = (state_ff == DV_DONE);
      rsp.zero = zero_ff;
      if (neg_ff) begin
         rsp.quot = (lo_ff > 32'h8000_0000) ? 32'sh80000000 : q_type'(~lo_ff + 1'b1);
      end else begin
         rsp.quot = (lo_ff > 32'h7fff_ffff) ? 32'sh7fffffff : q_type'(lo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

endmodule

// File: rtl/core/tridiagonal_system_solver.sv
// row zero needs one division from request to ready; later rows need two in the shared
// divider, ratio then forward value, with multiply, pivot and numerator states between
// one request at a time; after the last row, read and bsub states come between results
// results come highest row first; the rsp register holds until taken
// synchronous active-high reset clears the sequencer, pivot, count and singular flag
// the ratio and forward rams need no clearing: every entry is written before it is read
`timescale 1ns / 1ps

module tridiagonal_system_solver (
   input  logic       clock,
   input  logic       reset,
   tss_req_if.sink    req_chan,
   tss_rsp_if.source  rsp_chan
);
   import tss_pkg::*;

   tss_state_type state_ff, state_in;

   q_type        a_ff, a_in, b_ff, b_in, c_ff, c_in;
   q_type        num_ff, num_in, pivot_ff, pivot_in, prev_super_ff, prev_super_in;
   q_type        ratio_ff, ratio_in, gprev_ff, gprev_in, x_ff, x_in;
   logic         last_ff, last_in, err_ff, err_in;
   row_idx_type  cnt_ff, cnt_in, row_ff, row_in;
   logic [63:0]  prod_ff, prod_in;
   logic         pneg_ff, pneg_in;

   q_type            mul_x, mul_y;
   logic             div_start;
   q_type            div_num, div_den;
   tss_div_rsp_type  div_rsp;
   logic             req_acc, rsp_acc;
   logic             r_we, f_we;
   q_type            r_rdata, f_rdata;
   logic [31:0]      r_rd_raw, f_rd_raw;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign r_rdata = q_type'(r_rd_raw);
   assign f_rdata = q_type'(f_rd_raw);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc) state_in = (cnt_ff == '0) ? ST_GDIV : ST_DIV_R;
         ST_DIV_R: if (div_rsp.done) state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_PIV;
         ST_PIV:   state_in = ST_MUL_G;
         ST_MUL_G: state_in = ST_NUM;
         ST_NUM:   state_in = ST_GDIV;
         ST_GDIV:  state_in = ST_DIV_G;
         ST_DIV_G: if (div_rsp.done) state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (rsp_acc) state_in = (row_ff == '0) ? ST_IDLE : ST_RD;
         ST_RD:    state_in = ST_BSUB;
         ST_BSUB:  state_in = ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; num_in = num_ff;
      pivot_in = pivot_ff; prev_super_in = prev_super_ff;
      ratio_in = ratio_ff; gprev_in = gprev_ff; x_in = x_ff;
      last_in = last_ff; err_in = err_ff; cnt_in = cnt_ff; row_in = row_ff;
      req_chan.ready = (state_ff == ST_IDLE);
      div_start = 1'b0;
      div_num   = prev_super_ff;
      div_den   = pivot_ff;
      r_we = 1'b0;
      f_we = 1'b0;
      mul_x = a_ff;
      mul_y = ratio_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               a_in    = req_chan.sub_diag;
               b_in    = req_chan.main_diag;
               c_in    = req_chan.super_diag;
               num_in  = req_chan.rhs_value;
               last_in = req_chan.last_row || (cnt_ff == row_idx_type'(MAX_ROWS - 1));
               if (cnt_ff == '0) begin
                  pivot_in = req_chan.main_diag;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_DIV_R: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot;
               err_in   = err_ff | div_rsp.zero;
               r_we     = 1'b1;
            end
         end
         ST_PIV: pivot_in = sat32(43'(b_ff) - 43'(qround(prod_ff, pneg_ff)));
         ST_MUL_G: mul_y = gprev_ff;
         ST_NUM: num_in = sat32(43'(num_ff) - 43'(qround(prod_ff, pneg_ff)));
         ST_GDIV: begin
            div_start = 1'b1;
            div_num   = num_ff;
         end
         ST_DIV_G: begin
            if (div_rsp.done) begin
               gprev_in      = div_rsp.quot;
               x_in          = div_rsp.quot;
               row_in        = cnt_ff;
               err_in        = err_ff | div_rsp.zero;
               f_we          = 1'b1;
               prev_super_in = c_ff;
               cnt_in        = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_acc && row_ff == '0) begin
               pivot_in      = '0;
               prev_super_in = '0;
               cnt_in        = '0;
               err_in        = 1'b0;
            end
         end
         ST_RD: begin
            mul_x = r_rdata;
            mul_y = x_ff;
         end
         ST_BSUB: begin
            x_in   = sat32(43'(f_rdata) - 43'(qround(prod_ff, pneg_ff)));
            row_in = row_ff - 1'b1;
         end
         default: ;
      endcase
      // unsigned product of magnitudes, rounded in the following state
      prod_in = 64'(mag32(mul_x)) * 64'(mag32(mul_y));
      pneg_in = mul_x[31] ^ mul_y[31];
   end

   // rsp register view
   assign rsp_chan.valid     = (state_ff == ST_EMIT);
   assign rsp_chan.row_index = row_ff;
   assign rsp_chan.solution  = x_ff;
   assign rsp_chan.singular  = err_ff;
   assign rsp_chan.last_out  = (row_ff == '0);

   // num register carries the rhs, then the forward numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pivot_ff      <= '0;
         prev_super_ff <= '0;
         cnt_ff        <= '0;
         err_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pivot_ff      <= pivot_in;
         prev_super_ff <= prev_super_in;
         cnt_ff        <= cnt_in;
         err_ff        <= err_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      num_ff   <= num_in;
      ratio_ff <= ratio_in;
      gprev_ff <= gprev_in;
      x_ff     <= x_in;
      last_ff  <= last_in;
      row_ff   <= row_in;
      prod_ff  <= prod_in;
      pneg_ff  <= pneg_in;
   end

   tss_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_ratio_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (cnt_ff),
      .wdata (32'(div_rsp.quot)),
      .raddr (row_ff),
      .rdata (r_rd_raw)
   );

   tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_fwd_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (cnt_ff),
      .wdata (32'(div_rsp.quot)),
      .raddr (row_ff - 1'b1),
      .rdata (f_rd_raw)
   );

   // divider only answers while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_R || state_ff == ST_DIV_G))
      else $error("divider result outside a wait state");

   // rows descend by one between consecutive results
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && !rsp_chan.last_out) |-> ##3
      (rsp_chan.valid &&
       rsp_chan.row_index == row_idx_type'($past(rsp_chan.row_index, 3) - 1'b1)))
      else $error("backward sweep row order broken");

   // end of system clears run state
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_chan.last_out) |=> (!err_ff && cnt_ff == '0 && pivot_ff == '0))
      else $error("run state not cleared after row zero");

   // no new request while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken during backward sweep");

endmodule
